// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside reset.
`define SBT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sbt assertion failed");

// Check at every edge, reset included.
`define SBT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sbt assertion failed");

`endif

// ===== rtl/core/sbt_pkg.sv =====
// Types and constants of the software breakpoint table.
package sbt_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_STOP   = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_PROC = 1'b1
    } state_t;

    localparam logic [1:0] MEM_OP_NONE    = 2'd0;
    localparam logic [1:0] MEM_OP_EBREAK  = 2'd1;
    localparam logic [1:0] MEM_OP_RESTORE = 2'd2;

    localparam logic [1:0] KIND_ILLEGAL = 2'd0;
    localparam logic [1:0] KIND_TRAP    = 2'd1;
    localparam logic [1:0] KIND_GENERIC = 2'd2;

    localparam logic [7:0] SIG_ILLEGAL = 8'd4;
    localparam logic [7:0] SIG_TRAP    = 8'd5;
    localparam logic [7:0] SIG_GENERIC = 8'd25;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

endpackage

// ===== rtl/core/software_breakpoint_table_top.sv =====
// Software breakpoint table: per hart and task breakpoint slots in a row memory.
//
// Input channel s_*: one command per transfer (add, remove, update, stop).
// Result channel m_*: exactly one result per command, in order.
// Each group (hart, task) is one row of the row memory: SLOTS addresses,
// enable bits, applied bits and the stop flag. Saved words live in a second
// memory, one entry per slot. Both are read on the input transfer; the row
// is written back and the result register loaded when the command commits
// in the processing state, and the next command is taken only after that
// commit, so one command is in flight at a time.
// The result register frees the input side: a new command is taken while a
// result waits. If the result register is still full when a command finishes,
// the write-back holds until the receiver takes the waiting result.
// Reset clears the per-row valid bits, so every row reads as empty with no
// stop reported; the block is ready in the first cycle after reset.
// Commands with hart or task beyond the configured range give an all-zero
// result and change nothing.
module software_breakpoint_table_top #(
    parameter int HARTS = 2,
    parameter int TASKS = 16,
    parameter int SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic        s_hart_id,
    input  logic [3:0]  s_task_id,
    input  logic [2:0]  s_slot_index,
    input  logic [31:0] s_bp_address,
    input  logic [31:0] s_memory_word,
    input  logic [1:0]  s_signal_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_mem_op,
    output logic [31:0] m_mem_address,
    output logic [31:0] m_write_word,
    output logic        m_stop_report,
    output logic [7:0]  m_stop_signal,
    output logic [3:0]  m_stop_thread,
    output logic        m_group_full,
    output logic        m_not_found
);

    localparam int GROUPS  = HARTS * TASKS;
    localparam int ENTRIES = GROUPS * SLOTS;
    localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EN_LO   = SLOTS * 32;
    localparam int AP_LO   = EN_LO + SLOTS;
    localparam int STOP_B  = AP_LO + SLOTS;
    localparam int ROW_W   = STOP_B + 1;

    sbt_pkg::state_t state_reg, state_next;

    logic [ROW_W-1:0]  row_mem [GROUPS];
    logic [31:0]       saved_mem [ENTRIES];
    logic [GROUPS-1:0] row_valid_reg;

    logic [ROW_W-1:0]  row_rd_reg;
    logic [31:0]       saved_rd_reg;
    logic              rd_valid_reg;

    sbt_pkg::action_t  act_reg;
    logic [3:0]        task_reg;
    logic [2:0]        slot_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       word_reg;
    logic [1:0]        kind_reg;
    logic              inrange_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [ENT_W-1:0]  ent_reg;

    logic              accept;
    logic              commit;
    logic              in_range;
    logic [11:0]       grp_wide;
    logic [15:0]       ent_wide;
    logic [GRP_W-1:0]  grp_in;
    logic [ENT_W-1:0]  ent_in;

    logic [ROW_W-1:0]  row_cur;
    logic [ROW_W-1:0]  row_new;
    logic              wr_row;
    logic              wr_saved;
    logic              free_hit;
    logic              match_hit;
    logic              slot_ok;
    logic [31:0]       sel_addr;
    logic              sel_en;
    logic              sel_ap;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        mem_op_reg, mem_op_next;
    logic [31:0]       mem_addr_reg, mem_addr_next;
    logic [31:0]       wword_reg, wword_next;
    logic              stop_rep_reg, stop_rep_next;
    logic [7:0]        stop_sig_reg, stop_sig_next;
    logic [3:0]        stop_thr_reg, stop_thr_next;
    logic              full_reg, full_next;
    logic              nf_reg, nf_next;

    // Group and entry of the incoming command.
    always_comb begin
        in_range = ({3'b000, s_hart_id} < 4'(HARTS)) && ({3'b000, s_task_id} < 7'(TASKS));
        grp_wide = 12'(s_hart_id) * 12'(TASKS) + 12'(s_task_id);
        ent_wide = 16'(grp_wide) * 16'(SLOTS) + 16'(s_slot_index);
        grp_in   = in_range ? GRP_W'(grp_wide) : '0;
        ent_in   = in_range ? ENT_W'(ent_wide) : '0;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sbt_pkg::ST_PROC;
                end
            end
            sbt_pkg::ST_PROC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = sbt_pkg::ST_IDLE;
                end
            end
            default: state_next = sbt_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_ready = 1'b0;
        commit  = 1'b0;
        unique case (state_reg)
            sbt_pkg::ST_IDLE: s_ready = 1'b1;
            sbt_pkg::ST_PROC: commit  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the command.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg     <= sbt_pkg::action_t'(s_action);
            task_reg    <= s_task_id;
            slot_reg    <= s_slot_index;
            addr_reg    <= s_bp_address;
            word_reg    <= s_memory_word;
            kind_reg    <= s_signal_kind;
            inrange_reg <= in_range;
            grp_reg     <= grp_in;
            ent_reg     <= ent_in;
        end
    end

    // Row memory.
    always_ff @(posedge aclk) begin
        if (commit && wr_row) begin
            row_mem[grp_reg] <= row_new;
        end
        if (accept) begin
            row_rd_reg <= row_mem[grp_in];
        end
    end

    // Saved word memory.
    always_ff @(posedge aclk) begin
        if (commit && wr_saved) begin
            saved_mem[ent_reg] <= word_reg;
        end
        if (accept) begin
            saved_rd_reg <= saved_mem[ent_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                rd_valid_reg <= row_valid_reg[grp_in];
            end
            if (commit && wr_row) begin
                row_valid_reg[grp_reg] <= 1'b1;
            end
        end
    end

    // Modify the row.
    always_comb begin
        row_cur       = rd_valid_reg ? row_rd_reg : '0;
        row_new       = row_cur;
        wr_row        = inrange_reg;
        wr_saved      = 1'b0;
        free_hit      = 1'b0;
        match_hit     = 1'b0;
        slot_ok       = {3'b000, slot_reg} < 6'(SLOTS);
        sel_addr      = '0;
        sel_en        = 1'b0;
        sel_ap        = 1'b0;
        mem_op_next   = sbt_pkg::MEM_OP_NONE;
        mem_addr_next = '0;
        wword_next    = '0;
        stop_rep_next = 1'b0;
        stop_sig_next = '0;
        stop_thr_next = '0;
        full_next     = 1'b0;
        nf_next       = 1'b0;

        for (int i = 0; i < SLOTS; i++) begin
            if ({3'b000, slot_reg} == 6'(i)) begin
                sel_addr = row_cur[i*32 +: 32];
                sel_en   = row_cur[EN_LO + i];
                sel_ap   = row_cur[AP_LO + i];
            end
        end

        if (inrange_reg) begin
            unique case (act_reg)
                sbt_pkg::ACT_ADD: begin
                    if (addr_reg != '0) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!free_hit && row_cur[i*32 +: 32] == '0) begin
                                free_hit             = 1'b1;
                                row_new[i*32 +: 32]  = addr_reg;
                                row_new[EN_LO + i]   = 1'b1;
                            end
                        end
                        full_next = !free_hit;
                    end
                end
                sbt_pkg::ACT_REMOVE: begin
                    if (addr_reg != '0) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!match_hit && row_cur[i*32 +: 32] == addr_reg
                                    && row_cur[EN_LO + i]) begin
                                match_hit          = 1'b1;
                                row_new[EN_LO + i] = 1'b0;
                                if (!row_cur[AP_LO + i]) begin
                                    row_new[i*32 +: 32] = '0;
                                end
                            end
                        end
                        nf_next = !match_hit;
                    end
                end
                sbt_pkg::ACT_UPDATE: begin
                    if (slot_ok && sel_addr != '0 && sel_en != sel_ap) begin
                        mem_addr_next = sel_addr;
                        for (int i = 0; i < SLOTS; i++) begin
                            if ({3'b000, slot_reg} == 6'(i)) begin
                                row_new[AP_LO + i] = sel_en;
                                if (!sel_en) begin
                                    row_new[i*32 +: 32] = '0;
                                end
                            end
                        end
                        if (sel_en) begin
                            wr_saved    = 1'b1;
                            mem_op_next = sbt_pkg::MEM_OP_EBREAK;
                            wword_next  = sbt_pkg::EBREAK_WORD;
                        end else begin
                            mem_op_next = sbt_pkg::MEM_OP_RESTORE;
                            wword_next  = saved_rd_reg;
                        end
                    end
                end
                sbt_pkg::ACT_STOP: begin
                    if (!row_cur[STOP_B]) begin
                        row_new[STOP_B] = 1'b1;
                        stop_rep_next   = 1'b1;
                        stop_thr_next   = task_reg;
                        case (kind_reg)
                            sbt_pkg::KIND_ILLEGAL: stop_sig_next = sbt_pkg::SIG_ILLEGAL;
                            sbt_pkg::KIND_TRAP:    stop_sig_next = sbt_pkg::SIG_TRAP;
                            default:               stop_sig_next = sbt_pkg::SIG_GENERIC;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            mem_op_reg   <= mem_op_next;
            mem_addr_reg <= mem_addr_next;
            wword_reg    <= wword_next;
            stop_rep_reg <= stop_rep_next;
            stop_sig_reg <= stop_sig_next;
            stop_thr_reg <= stop_thr_next;
            full_reg     <= full_next;
            nf_reg       <= nf_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mem_op      = mem_op_reg;
    assign m_mem_address = mem_addr_reg;
    assign m_write_word  = wword_reg;
    assign m_stop_report = stop_rep_reg;
    assign m_stop_signal = stop_sig_reg;
    assign m_stop_thread = stop_thr_reg;
    assign m_group_full  = full_reg;
    assign m_not_found   = nf_reg;

endmodule

// ===== rtl/core/sbt_checker.sv =====
// Port checker for the software breakpoint table and its bind.
`include "assert_macros.svh"

module sbt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_mem_op,
    input logic [31:0] m_mem_address,
    input logic [31:0] m_write_word,
    input logic        m_stop_report,
    input logic [7:0]  m_stop_signal,
    input logic [3:0]  m_stop_thread,
    input logic        m_group_full,
    input logic        m_not_found
);

    logic [80:0] res_bits;
    logic        res_ok;

    assign res_bits = {m_mem_op, m_mem_address, m_write_word, m_stop_report, m_stop_signal,
                       m_stop_thread, m_group_full, m_not_found};

    assign res_ok = !(m_group_full && m_not_found)
        && (m_mem_op != sbt_pkg::MEM_OP_NONE || (m_mem_address == '0 && m_write_word == '0))
        && (m_stop_report || (m_stop_signal == '0 && m_stop_thread == '0));

    `SBT_ASSERT_ALWAYS(a_reset_drains, aclk, !aresetn |=> !m_valid)
    `SBT_ASSERT(a_one_in_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    `SBT_ASSERT(a_result_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `SBT_ASSERT(a_payload_holds, aclk, aresetn, m_valid && !m_ready |=> $stable(res_bits))
    `SBT_ASSERT(a_result_clean, aclk, aresetn, m_valid |-> res_ok)

endmodule

bind software_breakpoint_table_top sbt_checker u_sbt_checker (.*);
